[rtl/ptt_pkg.sv]
`default_nettype none

package ptt_pkg;

  localparam int TIMERS_DEF    = 16;
  localparam int TIME_BITS_DEF = 32;

  // A single scan fires no more than this many timers.
  localparam int FIRE_LIMIT = 16;

  localparam logic [31:0] MIN_PERIOD_RST = 32'd2000;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [2:0] KIND_FIRED = 3'd0;
  localparam logic [2:0] KIND_DONE  = 3'd1;
  localparam logic [2:0] KIND_DUP   = 3'd2;
  localparam logic [2:0] KIND_FULL  = 3'd3;
  localparam logic [2:0] KIND_NONE  = 3'd4;
  localparam logic [2:0] KIND_SHORT = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  owner;
    logic [7:0]  name_key;
    logic [31:0] period;
    logic        once;
    logic [31:0] now;
  } ptt_in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] fired_owner;
    logic [7:0] fired_key;
    logic       last;
  } ptt_out_t;

  typedef struct packed {
    logic [3:0]  owner;
    logic [7:0]  key;
    logic [31:0] period;
    logic        once;
  } ptt_meta_t;

  typedef struct packed {
    logic rd_en;
    logic meta_en;
    logic last_en;
    logic set_valid;
    logic clr_valid;
  } ptt_ctl_t;

  typedef struct packed {
    logic key_hit;
    logic own_hit;
    logic due;
  } ptt_hit_t;

endpackage

`default_nettype wire

[rtl/periodic_oneshot_timer_table.sv]
// Channel   Direction  Handshake            Word
// in_       input      in_valid/in_ready    ptt_pkg::ptt_in_t
// out_      output     out_valid/out_ready  ptt_pkg::ptt_out_t
// cfg_      input      cfg_we               cfg_wdata (min_period)
//
// A scanning tick, add, remove or clear is taken in ST_IDLE, walks the
// slots in ST_SCAN through the registered read port and the one compare
// unit, and presents the closing word in ST_FINISH.
// A tick that does not scan and an add with too short a period skip ST_SCAN.
// Reset clears the valid bits and the phase bit and reloads min_period.
// A stall on out_ready holds the scan.
`default_nettype none

module periodic_oneshot_timer_table #(
  parameter int TIMERS    = ptt_pkg::TIMERS_DEF,
  parameter int TIME_BITS = ptt_pkg::TIME_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  ptt_pkg::ptt_in_t   in_word,
  output logic               out_valid,
  input  wire                out_ready,
  output ptt_pkg::ptt_out_t  out_word,
  input  wire                cfg_we,
  input  wire [31:0]         cfg_wdata
);

  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  ptt_pkg::ptt_in_t     req;
  ptt_pkg::ptt_ctl_t    ctl;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  ptt_pkg::ptt_meta_t   wr_meta;
  logic [TIME_BITS-1:0] wr_last;
  ptt_pkg::ptt_meta_t   q_meta;
  logic [TIME_BITS-1:0] q_last;
  logic                 q_slot_valid;
  ptt_pkg::ptt_hit_t    hit;

  ptt_store #(
    .TIMERS    (TIMERS),
    .TIME_BITS (TIME_BITS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_meta  (wr_meta),
    .wr_last  (wr_last),
    .rd_meta  (q_meta),
    .rd_last  (q_last),
    .rd_valid (q_slot_valid)
  );

  ptt_cmp #(
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .req        (req),
    .meta       (q_meta),
    .last_time  (q_last),
    .slot_valid (q_slot_valid),
    .hit        (hit)
  );

  ptt_seq #(
    .TIMERS    (TIMERS),
    .TIME_BITS (TIME_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_word),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req          (req),
    .ctl          (ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_meta      (wr_meta),
    .wr_last      (wr_last),
    .q_meta       (q_meta),
    .q_slot_valid (q_slot_valid),
    .hit          (hit)
  );

endmodule

`default_nettype wire

[rtl/ptt_store.sv]
`default_nettype none

module ptt_store #(
  parameter int TIMERS    = ptt_pkg::TIMERS_DEF,
  parameter int TIME_BITS = ptt_pkg::TIME_BITS_DEF,
  localparam int IDX_W    = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  ptt_pkg::ptt_ctl_t       ctl,
  input  wire [IDX_W-1:0]         rd_addr,
  input  wire [IDX_W-1:0]         wr_addr,
  input  ptt_pkg::ptt_meta_t      wr_meta,
  input  wire [TIME_BITS-1:0]     wr_last,
  output ptt_pkg::ptt_meta_t      rd_meta,
  output logic [TIME_BITS-1:0]    rd_last,
  output logic                    rd_valid
);

  ptt_pkg::ptt_meta_t     meta_mem [TIMERS];
  logic [TIME_BITS-1:0]   last_mem [TIMERS];
  logic [TIMERS-1:0]      valid_r;
  logic [IDX_W-1:0]       rd_addr_r;
  ptt_pkg::ptt_meta_t     rd_meta_r;
  logic [TIME_BITS-1:0]   rd_last_r;

  always_ff @(posedge clk) begin
    if (ctl.meta_en) begin
      meta_mem[wr_addr] <= wr_meta;
    end
    if (ctl.last_en) begin
      last_mem[wr_addr] <= wr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_meta_r <= meta_mem[rd_addr];
      rd_last_r <= last_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      rd_addr_r <= '0;
    end else begin
      if (ctl.rd_en) begin
        rd_addr_r <= rd_addr;
      end
      if (ctl.set_valid) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (ctl.clr_valid) begin
        valid_r[wr_addr] <= 1'b0;
      end
    end
  end

  // The valid bit is looked up live so that clears made earlier in the
  // same scan are seen.
  assign rd_meta  = rd_meta_r;
  assign rd_last  = rd_last_r;
  assign rd_valid = valid_r[rd_addr_r];

endmodule

`default_nettype wire

[rtl/ptt_cmp.sv]
`default_nettype none

module ptt_cmp #(
  parameter int TIME_BITS = ptt_pkg::TIME_BITS_DEF
) (
  input  ptt_pkg::ptt_in_t     req,
  input  ptt_pkg::ptt_meta_t   meta,
  input  wire [TIME_BITS-1:0]  last_time,
  input  wire                  slot_valid,
  output ptt_pkg::ptt_hit_t    hit
);

  localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

  logic [TIME_BITS-1:0] now_t;
  logic [SUM_W-1:0]     due_at;

  assign now_t  = TIME_BITS'(req.now);
  // The sum keeps its carry, so a deadline past the top of the time range
  // is never due.
  assign due_at = SUM_W'(last_time) + SUM_W'(meta.period);

  always_comb begin
    hit.own_hit = slot_valid && (meta.owner == req.owner);
    hit.key_hit = hit.own_hit && (meta.key == req.name_key);
    hit.due     = slot_valid && (due_at <= SUM_W'(now_t));
  end

endmodule

`default_nettype wire

[rtl/ptt_seq.sv]
`default_nettype none

module ptt_seq #(
  parameter int TIMERS    = ptt_pkg::TIMERS_DEF,
  parameter int TIME_BITS = ptt_pkg::TIME_BITS_DEF,
  localparam int IDX_W    = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  ptt_pkg::ptt_in_t        in_word,
  output logic                    out_valid,
  input  wire                     out_ready,
  output ptt_pkg::ptt_out_t       out_word,
  input  wire                     cfg_we,
  input  wire [31:0]              cfg_wdata,
  output ptt_pkg::ptt_in_t        req,
  output ptt_pkg::ptt_ctl_t       ctl,
  output logic [IDX_W-1:0]        rd_addr,
  output logic [IDX_W-1:0]        wr_addr,
  output ptt_pkg::ptt_meta_t      wr_meta,
  output logic [TIME_BITS-1:0]    wr_last,
  input  ptt_pkg::ptt_meta_t      q_meta,
  input  wire                     q_slot_valid,
  input  ptt_pkg::ptt_hit_t       hit
);

  localparam int CNT_W  = $clog2(TIMERS + 1);
  localparam int FIRE_W = $clog2(ptt_pkg::FIRE_LIMIT + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic                phase_r, phase_nxt;
  ptt_pkg::ptt_in_t    req_r, req_nxt;
  logic                short_r, short_nxt;
  logic [CNT_W-1:0]    iss_r, iss_nxt;
  logic                q_vld_r, q_vld_nxt;
  logic [IDX_W-1:0]    q_idx_r, q_idx_nxt;
  logic [FIRE_W-1:0]   fires_r, fires_nxt;
  logic                dup_r, dup_nxt;
  logic                found_r, found_nxt;
  logic                free_found_r, free_found_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [31:0]         min_period_r, min_period_nxt;
  logic                out_valid_r, out_valid_nxt;
  ptt_pkg::ptt_out_t   out_word_r, out_word_nxt;

  logic                out_free;
  logic                fire_ok;
  logic                need_emit;
  logic                adv;
  logic                more_slots;
  logic                add_write;
  ptt_pkg::ptt_out_t   final_word;
  ptt_pkg::ptt_out_t   fire_word;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  assign req        = req_r;
  assign rd_addr    = iss_r[IDX_W-1:0];
  assign wr_last    = TIME_BITS'(req_r.now);

  assign out_free   = !out_valid_r || out_ready;
  assign fire_ok    = hit.due && (fires_r < FIRE_W'(ptt_pkg::FIRE_LIMIT));
  assign need_emit  = q_vld_r && (req_r.cmd == ptt_pkg::CMD_TICK) && fire_ok;
  // The scan pipeline holds while a fired word cannot be handed on.
  assign adv        = (state_r == ST_SCAN) && !(need_emit && !out_free);
  assign more_slots = (iss_r < CNT_W'(TIMERS));
  assign add_write  = (req_r.cmd == ptt_pkg::CMD_ADD) && !short_r && !dup_r && free_found_r;

  always_comb begin
    wr_meta.owner  = req_r.owner;
    wr_meta.key    = req_r.name_key;
    wr_meta.period = req_r.period;
    wr_meta.once   = req_r.once;
  end

  always_comb begin
    fire_word.kind        = ptt_pkg::KIND_FIRED;
    fire_word.fired_owner = q_meta.owner;
    fire_word.fired_key   = q_meta.key;
    fire_word.last        = 1'b0;
  end

  always_comb begin
    final_word.last        = 1'b1;
    final_word.fired_owner = req_r.owner;
    final_word.fired_key   = req_r.name_key;
    final_word.kind        = ptt_pkg::KIND_DONE;
    unique case (req_r.cmd)
      ptt_pkg::CMD_TICK: begin
        final_word.fired_owner = '0;
        final_word.fired_key   = '0;
      end
      ptt_pkg::CMD_ADD: begin
        priority if (short_r) begin
          final_word.kind = ptt_pkg::KIND_SHORT;
        end else if (dup_r) begin
          final_word.kind = ptt_pkg::KIND_DUP;
        end else if (!free_found_r) begin
          final_word.kind = ptt_pkg::KIND_FULL;
        end else begin
          final_word.kind = ptt_pkg::KIND_DONE;
        end
      end
      ptt_pkg::CMD_REMOVE: begin
        final_word.kind = found_r ? ptt_pkg::KIND_DONE : ptt_pkg::KIND_NONE;
      end
      ptt_pkg::CMD_CLEAR: begin
        final_word.fired_key = '0;
      end
      default: begin
        final_word.kind = ptt_pkg::KIND_DONE;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    req_nxt        = req_r;
    short_nxt      = short_r;
    iss_nxt        = iss_r;
    q_vld_nxt      = q_vld_r;
    q_idx_nxt      = q_idx_r;
    fires_nxt      = fires_r;
    dup_nxt        = dup_r;
    found_nxt      = found_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    min_period_nxt = cfg_we ? cfg_wdata : min_period_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_word_nxt   = out_word_r;
    ctl            = '0;
    wr_addr        = q_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_word;
          iss_nxt        = '0;
          q_vld_nxt      = 1'b0;
          fires_nxt      = '0;
          dup_nxt        = 1'b0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          short_nxt      = (in_word.period < min_period_r);
          if (in_word.cmd == ptt_pkg::CMD_TICK) begin
            // Only a tick that raises the phase bit scans the table.
            phase_nxt = ~phase_r;
            state_nxt = phase_r ? ST_FINISH : ST_SCAN;
          end else if ((in_word.cmd == ptt_pkg::CMD_ADD) &&
                       (in_word.period < min_period_r)) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!q_vld_r && !more_slots) begin
          state_nxt = ST_FINISH;
        end else if (adv) begin
          if (more_slots) begin
            ctl.rd_en = 1'b1;
            q_vld_nxt = 1'b1;
            q_idx_nxt = iss_r[IDX_W-1:0];
            iss_nxt   = iss_r + CNT_W'(1);
          end else begin
            // The last slot is handled in this cycle.
            q_vld_nxt = 1'b0;
            state_nxt = ST_FINISH;
          end
          if (q_vld_r) begin
            unique case (req_r.cmd)
              ptt_pkg::CMD_TICK: begin
                if (fire_ok) begin
                  out_valid_nxt = 1'b1;
                  out_word_nxt  = fire_word;
                  fires_nxt     = fires_r + FIRE_W'(1);
                  if (q_meta.once) begin
                    ctl.clr_valid = 1'b1;
                  end else begin
                    ctl.last_en = 1'b1;
                  end
                end
              end
              ptt_pkg::CMD_ADD: begin
                if (hit.key_hit) begin
                  dup_nxt = 1'b1;
                end
                if (!q_slot_valid && !free_found_r) begin
                  free_found_nxt = 1'b1;
                  free_idx_nxt   = q_idx_r;
                end
              end
              ptt_pkg::CMD_REMOVE: begin
                if (hit.key_hit && !found_r) begin
                  found_nxt     = 1'b1;
                  ctl.clr_valid = 1'b1;
                end
              end
              ptt_pkg::CMD_CLEAR: begin
                if (hit.own_hit) begin
                  ctl.clr_valid = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = final_word;
          if (add_write) begin
            ctl.meta_en   = 1'b1;
            ctl.last_en   = 1'b1;
            ctl.set_valid = 1'b1;
            wr_addr       = free_idx_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= 1'b0;
      q_vld_r      <= 1'b0;
      iss_r        <= '0;
      fires_r      <= '0;
      dup_r        <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      short_r      <= 1'b0;
      min_period_r <= ptt_pkg::MIN_PERIOD_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      q_vld_r      <= q_vld_nxt;
      iss_r        <= iss_nxt;
      fires_r      <= fires_nxt;
      dup_r        <= dup_nxt;
      found_r      <= found_nxt;
      free_found_r <= free_found_nxt;
      short_r      <= short_nxt;
      min_period_r <= min_period_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    q_idx_r    <= q_idx_nxt;
    free_idx_r <= free_idx_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire

[rtl/ptt_checker.sv]
`default_nettype none

module ptt_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input ptt_pkg::ptt_out_t out_word
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // Only fired words leave the closing flag low.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_word.kind == ptt_pkg::KIND_FIRED) == !out_word.last))
    else $error("closing flag does not match the word kind");

  // The block works on one command at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in flight");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind periodic_oneshot_timer_table ptt_checker u_ptt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ptt_pkg::ptt_in_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ptt_pkg::ptt_out_t out_word;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // Shadow copy of the timer table and its registers.
  logic tmr_valid [ptt_pkg::TIMERS_DEF];
  logic [3:0] tmr_owner [ptt_pkg::TIMERS_DEF];
  logic [7:0] tmr_key [ptt_pkg::TIMERS_DEF];
  logic [31:0] tmr_period [ptt_pkg::TIMERS_DEF];
  logic [31:0] tmr_last [ptt_pkg::TIMERS_DEF];
  logic tmr_once [ptt_pkg::TIMERS_DEF];
  logic scan_phase = 1'b0;
  logic [31:0] min_limit = ptt_pkg::MIN_PERIOD_RST;

  ptt_pkg::ptt_out_t expected_results [$];
  int err_count = 0;
  bit gaps_on = 1'b1;
  int stall_left = 0;
  logic [31:0] clock_ms = '0;

  periodic_oneshot_timer_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left = stall_left - 1;
    end else if (!gaps_on) begin
      out_ready = 1'b1;
    end else begin
      stall_left = pick_gap();
      out_ready = (stall_left == 0);
      if (stall_left != 0) stall_left = stall_left - 1;
    end
  end

  function automatic void push_result(input logic [2:0] kind, input logic [3:0] own,
                                      input logic [7:0] key, input logic fin);
    ptt_pkg::ptt_out_t r;
    r.kind = kind;
    r.fired_owner = own;
    r.fired_key = key;
    r.last = fin;
    expected_results.push_back(r);
  endfunction

  function automatic int find_timer(input logic [3:0] own, input logic [7:0] key);
    int i;
    for (i = 0; i < ptt_pkg::TIMERS_DEF; i++) begin
      if (tmr_valid[i] && tmr_owner[i] == own && tmr_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Works out the words that one accepted command causes and updates the table copy.
  function automatic void predict_results(input ptt_pkg::ptt_in_t w);
    int i;
    int slot;
    int fired;
    logic [32:0] due_at;
    case (w.cmd)
      ptt_pkg::CMD_TICK: begin
        scan_phase = ~scan_phase;
        fired = 0;
        if (scan_phase) begin
          for (i = 0; i < ptt_pkg::TIMERS_DEF; i++) begin
            if (tmr_valid[i] && fired < ptt_pkg::FIRE_LIMIT) begin
              // The sum is taken one bit wider so that it never wraps.
              due_at = {1'b0, tmr_last[i]} + {1'b0, tmr_period[i]};
              if (due_at <= {1'b0, w.now}) begin
                push_result(ptt_pkg::KIND_FIRED, tmr_owner[i], tmr_key[i], 1'b0);
                fired++;
                if (tmr_once[i]) tmr_valid[i] = 1'b0;
                else tmr_last[i] = w.now;
              end
            end
          end
        end
        push_result(ptt_pkg::KIND_DONE, 4'd0, 8'd0, 1'b1);
      end
      ptt_pkg::CMD_ADD: begin
        if (w.period < min_limit) begin
          push_result(ptt_pkg::KIND_SHORT, w.owner, w.name_key, 1'b1);
        end else if (find_timer(w.owner, w.name_key) >= 0) begin
          push_result(ptt_pkg::KIND_DUP, w.owner, w.name_key, 1'b1);
        end else begin
          slot = -1;
          for (i = ptt_pkg::TIMERS_DEF - 1; i >= 0; i--) begin
            if (!tmr_valid[i]) slot = i;
          end
          if (slot < 0) begin
            push_result(ptt_pkg::KIND_FULL, w.owner, w.name_key, 1'b1);
          end else begin
            tmr_valid[slot] = 1'b1;
            tmr_owner[slot] = w.owner;
            tmr_key[slot] = w.name_key;
            tmr_period[slot] = w.period;
            tmr_last[slot] = w.now;
            tmr_once[slot] = w.once;
            push_result(ptt_pkg::KIND_DONE, w.owner, w.name_key, 1'b1);
          end
        end
      end
      ptt_pkg::CMD_REMOVE: begin
        slot = find_timer(w.owner, w.name_key);
        if (slot >= 0) begin
          tmr_valid[slot] = 1'b0;
          push_result(ptt_pkg::KIND_DONE, w.owner, w.name_key, 1'b1);
        end else begin
          push_result(ptt_pkg::KIND_NONE, w.owner, w.name_key, 1'b1);
        end
      end
      default: begin
        for (i = 0; i < ptt_pkg::TIMERS_DEF; i++) begin
          if (tmr_valid[i] && tmr_owner[i] == w.owner) tmr_valid[i] = 1'b0;
        end
        push_result(ptt_pkg::KIND_DONE, w.owner, 8'd0, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, field, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : check_results
    ptt_pkg::ptt_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word, kind", out_word.kind, -1);
      end else begin
        want = expected_results.pop_front();
        if (out_word.kind !== want.kind)
          report_mismatch("kind", out_word.kind, want.kind);
        if (out_word.fired_owner !== want.fired_owner)
          report_mismatch("fired_owner", out_word.fired_owner, want.fired_owner);
        if (out_word.fired_key !== want.fired_key)
          report_mismatch("fired_key", out_word.fired_key, want.fired_key);
        if (out_word.last !== want.last)
          report_mismatch("last", out_word.last, want.last);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [1:0] cmd, input logic [3:0] own,
                           input logic [7:0] key, input logic [31:0] period,
                           input logic once, input logic [31:0] now);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    repeat (gap) @(negedge clk);
    in_word.cmd = cmd;
    in_word.owner = own;
    in_word.name_key = key;
    in_word.period = period;
    in_word.once = once;
    in_word.now = now;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_results(in_word);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_min_period(input logic [31:0] value);
    wait_drained();
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    min_limit = value;
  endtask

  task automatic test_add_checks();
    send_word(ptt_pkg::CMD_ADD, 4'd0, 8'd0, 32'd2000, 1'b0, 32'd0);
    send_word(ptt_pkg::CMD_ADD, 4'd0, 8'd0, 32'd1999, 1'b0, 32'd0);
    send_word(ptt_pkg::CMD_ADD, 4'd0, 8'd0, 32'd3000, 1'b1, 32'd0);
    send_word(ptt_pkg::CMD_ADD, 4'd15, 8'd255, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_word(ptt_pkg::CMD_REMOVE, 4'd4, 8'd4, 32'd0, 1'b0, 32'd0);
    send_word(ptt_pkg::CMD_ADD, 4'd4, 8'd4, 32'd2500, 1'b1, 32'd1000);
  endtask

  task automatic test_tick_phases();
    send_word(ptt_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 1'b0, 32'd1999);
    send_word(ptt_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 1'b0, 32'd5000);
    send_word(ptt_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 1'b0, 32'd5000);
    // The entry whose end time lies past the top of the counter must stay quiet.
    send_word(ptt_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
    send_word(ptt_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_remove_clear();
    send_word(ptt_pkg::CMD_REMOVE, 4'd4, 8'd4, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_word(ptt_pkg::CMD_REMOVE, 4'd0, 8'd0, 32'd0, 1'b0, 32'd0);
    send_word(ptt_pkg::CMD_CLEAR, 4'd9, 8'd77, 32'd0, 1'b0, 32'd0);
    send_word(ptt_pkg::CMD_CLEAR, 4'd15, 8'd255, 32'd0, 1'b0, 32'd0);
    send_word(ptt_pkg::CMD_REMOVE, 4'd15, 8'd255, 32'd0, 1'b0, 32'd0);
  endtask

  task automatic test_min_period();
    write_min_period(32'd0);
    send_word(ptt_pkg::CMD_ADD, 4'd1, 8'd1, 32'd0, 1'b0, 32'd100);
    send_word(ptt_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 1'b0, 32'd100);
    send_word(ptt_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 1'b0, 32'd100);
    write_min_period(32'hFFFF_FFFF);
    send_word(ptt_pkg::CMD_ADD, 4'd2, 8'd2, 32'hFFFF_FFFE, 1'b0, 32'd0);
    send_word(ptt_pkg::CMD_ADD, 4'd2, 8'd3, 32'hFFFF_FFFF, 1'b1, 32'd0);
    send_word(ptt_pkg::CMD_CLEAR, 4'd1, 8'd0, 32'd0, 1'b0, 32'd0);
    send_word(ptt_pkg::CMD_CLEAR, 4'd2, 8'd0, 32'd0, 1'b0, 32'd0);
    write_min_period(ptt_pkg::MIN_PERIOD_RST);
  endtask

  // Fills every slot, overflows the table, then lets one scan fire all entries.
  task automatic test_full_table();
    int i;
    for (i = 0; i <= ptt_pkg::TIMERS_DEF; i++) begin
      send_word(ptt_pkg::CMD_ADD, 4'($urandom_range(0, 3)), 8'(i),
                min_limit + $urandom_range(0, 100), 1'($urandom_range(0, 1)), clock_ms);
    end
    clock_ms = clock_ms + 32'd100000;
    send_word(ptt_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 1'b0, clock_ms);
    send_word(ptt_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 1'b0, clock_ms);
  endtask

  task automatic test_random_traffic(input int count);
    int n;
    int r;
    logic [1:0] cmd;
    logic [3:0] own;
    logic [7:0] key;
    logic [31:0] period;
    logic [31:0] now;
    longint wide;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      cmd = (r < 35) ? ptt_pkg::CMD_ADD : (r < 70) ? ptt_pkg::CMD_TICK :
            (r < 88) ? ptt_pkg::CMD_REMOVE : ptt_pkg::CMD_CLEAR;
      // A small pool of owners and keys makes duplicates and hits common.
      own = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      key = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      period = $urandom();
      now = $urandom();
      if (cmd == ptt_pkg::CMD_ADD) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          wide = longint'(min_limit) + $urandom_range(0, 6000);
          period = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(wide);
        end else if (r < 85 && min_limit != 0) begin
          period = $urandom_range(0, min_limit - 1);
        end
        now = clock_ms;
      end else if (cmd == ptt_pkg::CMD_TICK && $urandom_range(0, 9) != 0) begin
        clock_ms = clock_ms + $urandom_range(0, 5000);
        now = clock_ms;
      end
      send_word(cmd, own, key, period, 1'($urandom_range(0, 1)), now);
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < ptt_pkg::TIMERS_DEF; i++) tmr_valid[i] = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_add_checks();
    test_tick_phases();
    test_remove_clear();
    test_min_period();
    test_full_table();
    test_random_traffic(30);
    gaps_on = 1'b0;
    write_min_period(32'd0);
    test_random_traffic(20);
    gaps_on = 1'b1;
    write_min_period($urandom_range(1, 5000));
    test_random_traffic(28);

    wait_drained();
    repeat (ptt_pkg::TIMERS_DEF + 8) @(negedge clk);
    if (err_count == 0) begin
      $display("periodic_oneshot_timer_table test passed");
    end else begin
      $display("periodic_oneshot_timer_table test failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("periodic_oneshot_timer_table test failed");
    $finish;
  end

endmodule

`default_nettype wire
